FILE: rtl/cbs_pkg.sv
`timescale 1ns / 1ps

package cbs_pkg;

    // Default widths of the coordinate and split parameter fields
    localparam int COORD_BITS_DEF  = 24;
    localparam int T_FRAC_BITS_DEF = 16;

    // Coordinates carried in one item on either side
    localparam int NUM_COORDS = 8;

    // Field order within tdata, lowest bits first
    localparam int FLD_START_X = 0;
    localparam int FLD_START_Y = 1;
    localparam int FLD_END_X   = 2;
    localparam int FLD_END_Y   = 3;
    localparam int FLD_CTRLA_X = 4;
    localparam int FLD_CTRLA_Y = 5;
    localparam int FLD_CTRLB_X = 6;
    localparam int FLD_CTRLB_Y = 7;

    // Output serialiser phase codes
    localparam logic PHASE_LEFT  = 1'b0;
    localparam logic PHASE_RIGHT = 1'b1;

    // Load enables of the two register stages of one interpolation unit
    typedef struct packed {
        logic mul;
        logic add;
    } lerp_en_t;

endpackage

FILE: rtl/cbs_lerp.sv
`timescale 1ns / 1ps

module cbs_lerp import cbs_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  lerp_en_t                     en,
    input  logic signed [COORD_BITS-1:0] p,
    input  logic signed [COORD_BITS-1:0] q,
    input  logic        [T_FRAC_BITS:0]  t,
    output logic signed [COORD_BITS-1:0] r
);

    localparam int PROD_W = COORD_BITS + T_FRAC_BITS + 3;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (T_FRAC_BITS - 1);

    logic signed [COORD_BITS:0]   diff;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [COORD_BITS-1:0] p_reg;
    logic signed [PROD_W-1:0]     rnd;
    logic signed [PROD_W-1:0]     shifted;
    logic signed [COORD_BITS+1:0] step;
    logic signed [COORD_BITS+1:0] sum;
    logic signed [COORD_BITS-1:0] r_next;
    logic signed [COORD_BITS-1:0] r_reg;

    // Scale the difference by t
    always_comb begin
        diff      = $signed({q[COORD_BITS-1], q}) - $signed({p[COORD_BITS-1], p});
        prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, t}));
    end

    // Round to nearest, ties upward, and add the base point
    always_comb begin
        rnd     = prod_reg + HALF;
        shifted = rnd >>> T_FRAC_BITS;
        step    = $signed(shifted[COORD_BITS+1:0]);
        sum     = $signed({p_reg[COORD_BITS-1], p_reg[COORD_BITS-1], p_reg}) + step;
        r_next  = sum[COORD_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.mul) begin
            prod_reg <= prod_next;
            p_reg    <= p;
        end
        if (en.add) begin
            r_reg <= r_next;
        end
    end

    assign r = r_reg;

endmodule

FILE: rtl/cbs_out.sv
`timescale 1ns / 1ps

module cbs_out import cbs_pkg::*; #(
    parameter int DATA_W = 192
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic              load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tlast
);

    logic              valid_reg;
    logic              phase_reg;
    logic [DATA_W-1:0] left_reg;
    logic [DATA_W-1:0] right_reg;

    // Take a new pair once the right piece leaves or the buffer is empty
    assign load = !valid_reg || (m_tready && phase_reg == PHASE_RIGHT);

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= PHASE_LEFT;
        end else if (load) begin
            valid_reg <= in_valid;
            phase_reg <= PHASE_LEFT;
        end else if (m_tready) begin
            phase_reg <= PHASE_RIGHT;
        end
    end

    // Hold both pieces
    always_ff @(posedge aclk) begin
        if (load) begin
            left_reg  <= left_data;
            right_reg <= right_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = phase_reg;
    assign m_tdata  = (phase_reg == PHASE_RIGHT) ? right_reg : left_reg;

endmodule

FILE: rtl/cubic_bezier_split_top.sv
`timescale 1ns / 1ps
// Each curve crosses the pipeline; m_ then carries its left piece and then its right piece.
// Throughput: the output serialiser emits two items per curve and takes the next curve as
// the right piece leaves; the seven-stage interpolation pipeline itself takes one curve per
// cycle unless back-pressure from the serialiser or m_tready holds it.
// Reset: synchronous active-low aresetn clears every stage valid bit and the output buffer.

module cubic_bezier_split_top import cbs_pkg::*; #(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    localparam int IN_W  = ((NUM_COORDS * COORD_BITS + T_FRAC_BITS + 1 + 7) / 8) * 8,
    localparam int OUT_W = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // start_x, start_y, end_x, end_y, near_start_ctrl_x, near_start_ctrl_y,
    // near_end_ctrl_x, near_end_ctrl_y, split_t, zero pad
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // piece_start_x, piece_start_y, piece_end_x, piece_end_y, piece_ctrl_a_x,
    // piece_ctrl_a_y, piece_ctrl_b_x, piece_ctrl_b_y, zero pad
    output logic [OUT_W-1:0] m_tdata,
    output logic             m_tlast
);

    localparam int C = COORD_BITS;
    localparam logic [T_FRAC_BITS:0] T_ONE = (T_FRAC_BITS + 1)'(1) << T_FRAC_BITS;

    logic [6:0] v_reg;
    logic [6:0] en;
    logic       ob_load;

    logic        [T_FRAC_BITS:0]  t_in;
    logic        [T_FRAC_BITS:0]  t_reg  [0:4];
    logic signed [C-1:0]          p0_reg [0:6][0:1];
    logic signed [C-1:0]          p3_reg [0:6][0:1];
    logic signed [C-1:0]          p1_reg [0:1];
    logic signed [C-1:0]          p2_reg [0:1];
    logic signed [C-1:0]          q0_reg [3:6][0:1];
    logic signed [C-1:0]          q2_reg [3:6][0:1];
    logic signed [C-1:0]          r0_reg [5:6][0:1];
    logic signed [C-1:0]          r1_reg [5:6][0:1];

    logic signed [C-1:0] q0_w [0:1];
    logic signed [C-1:0] q1_w [0:1];
    logic signed [C-1:0] q2_w [0:1];
    logic signed [C-1:0] r0_w [0:1];
    logic signed [C-1:0] r1_w [0:1];
    logic signed [C-1:0] s_w  [0:1];

    logic [OUT_W-1:0] left_data;
    logic [OUT_W-1:0] right_data;

    lerp_en_t en_l1;
    lerp_en_t en_l2;
    lerp_en_t en_l3;

    // Advance a stage when it is empty or the next one advances
    always_comb begin
        en[6] = !v_reg[6] || ob_load;
        for (int i = 5; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign s_tready = en[0];
    assign en_l1 = '{mul: en[1], add: en[2]};
    assign en_l2 = '{mul: en[3], add: en[4]};
    assign en_l3 = '{mul: en[5], add: en[6]};

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < 7; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Saturate t above one
    always_comb begin
        t_in = s_tdata[NUM_COORDS*C +: T_FRAC_BITS+1];
        if (t_in > T_ONE) begin
            t_in = T_ONE;
        end
    end

    // Capture the input item, then delay t and the points that later levels
    // or the output still need
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t_reg[0] <= t_in;
            for (int d = 0; d < 2; d++) begin
                p0_reg[0][d] <= $signed(s_tdata[(FLD_START_X + d)*C +: C]);
                p3_reg[0][d] <= $signed(s_tdata[(FLD_END_X + d)*C +: C]);
                p1_reg[d]    <= $signed(s_tdata[(FLD_CTRLA_X + d)*C +: C]);
                p2_reg[d]    <= $signed(s_tdata[(FLD_CTRLB_X + d)*C +: C]);
            end
        end
        for (int i = 1; i < 5; i++) begin
            if (en[i]) begin
                t_reg[i] <= t_reg[i-1];
            end
        end
        for (int i = 1; i < 7; i++) begin
            if (en[i]) begin
                p0_reg[i] <= p0_reg[i-1];
                p3_reg[i] <= p3_reg[i-1];
            end
        end
        if (en[3]) begin
            q0_reg[3] <= q0_w;
            q2_reg[3] <= q2_w;
        end
        for (int i = 4; i < 7; i++) begin
            if (en[i]) begin
                q0_reg[i] <= q0_reg[i-1];
                q2_reg[i] <= q2_reg[i-1];
            end
        end
        if (en[5]) begin
            r0_reg[5] <= r0_w;
            r1_reg[5] <= r1_w;
        end
        if (en[6]) begin
            r0_reg[6] <= r0_reg[5];
            r1_reg[6] <= r1_reg[5];
        end
    end

    // Three interpolation levels, one unit per coordinate
    for (genvar d = 0; d < 2; d++) begin : g_dim
        cbs_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_q0 (
            .aclk(aclk), .en(en_l1), .p(p0_reg[0][d]), .q(p1_reg[d]),
            .t(t_reg[0]), .r(q0_w[d])
        );
        cbs_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_q1 (
            .aclk(aclk), .en(en_l1), .p(p1_reg[d]), .q(p2_reg[d]),
            .t(t_reg[0]), .r(q1_w[d])
        );
        cbs_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_q2 (
            .aclk(aclk), .en(en_l1), .p(p2_reg[d]), .q(p3_reg[0][d]),
            .t(t_reg[0]), .r(q2_w[d])
        );
        cbs_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_r0 (
            .aclk(aclk), .en(en_l2), .p(q0_w[d]), .q(q1_w[d]),
            .t(t_reg[2]), .r(r0_w[d])
        );
        cbs_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_r1 (
            .aclk(aclk), .en(en_l2), .p(q1_w[d]), .q(q2_w[d]),
            .t(t_reg[2]), .r(r1_w[d])
        );
        cbs_lerp #(.COORD_BITS(C), .T_FRAC_BITS(T_FRAC_BITS)) u_s (
            .aclk(aclk), .en(en_l3), .p(r0_w[d]), .q(r1_w[d]),
            .t(t_reg[4]), .r(s_w[d])
        );
    end

    // Pack both pieces
    always_comb begin
        left_data  = '0;
        right_data = '0;
        for (int d = 0; d < 2; d++) begin
            left_data[(FLD_START_X + d)*C +: C]  = p0_reg[6][d];
            left_data[(FLD_END_X + d)*C +: C]    = s_w[d];
            left_data[(FLD_CTRLA_X + d)*C +: C]  = q0_reg[6][d];
            left_data[(FLD_CTRLB_X + d)*C +: C]  = r0_reg[6][d];
            right_data[(FLD_START_X + d)*C +: C] = s_w[d];
            right_data[(FLD_END_X + d)*C +: C]   = p3_reg[6][d];
            right_data[(FLD_CTRLA_X + d)*C +: C] = r1_reg[6][d];
            right_data[(FLD_CTRLB_X + d)*C +: C] = q2_reg[6][d];
        end
    end

    cbs_out #(.DATA_W(OUT_W)) u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v_reg[6]),
        .left_data  (left_data),
        .right_data (right_data),
        .load       (ob_load),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: rtl/cbs_checker.sv
`timescale 1ns / 1ps

module cbs_checker import cbs_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int OUT_W      = 192
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // Follow a left piece directly with its right piece
    a_right_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("left piece not followed by right piece");

    // Start the right piece where the left piece ends
    a_split_joint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tdata[2*COORD_BITS-1:0] == $past(m_tdata[4*COORD_BITS-1:2*COORD_BITS]))
        else $error("right piece does not start at split point");

    // Drop every result after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind cubic_bezier_split_top cbs_checker #(
    .COORD_BITS (COORD_BITS),
    .OUT_W      (OUT_W)
) u_cbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import cbs_pkg::*;

    localparam int CW    = COORD_BITS_DEF;
    localparam int TW    = T_FRAC_BITS_DEF;
    localparam int IN_W  = ((NUM_COORDS * CW + TW + 1 + 7) / 8) * 8;
    localparam int OUT_W = ((NUM_COORDS * CW + 7) / 8) * 8;
    localparam int T_POS = NUM_COORDS * CW;
    localparam longint T_ONE = 64'sd1 <<< TW;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 24;
    localparam int COORD_MAX = (1 << (CW - 1)) - 1;
    localparam int COORD_MIN = -(1 << (CW - 1));

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t curve_pts_t [NUM_COORDS];

    typedef struct {
        logic [OUT_W-1:0] coords;
        logic             last;
    } piece_t;

    // Splits each accepted curve and checks the pieces in arrival order
    class piece_checker;
        piece_t pieces_due[$];
        int     mismatches;
        string  coord_names [NUM_COORDS];

        function new();
            mismatches = 0;
            coord_names = '{"piece_start_x", "piece_start_y", "piece_end_x", "piece_end_y",
                            "piece_ctrl_a_x", "piece_ctrl_a_y", "piece_ctrl_b_x",
                            "piece_ctrl_b_y"};
        endfunction

        // p + (q - p) * t, rounded to nearest with ties upwards
        function longint mix(longint p, longint q, longint t);
            longint prod;
            prod = (q - p) * t;
            return p + ((prod + (64'sd1 <<< (TW - 1))) >>> TW);
        endfunction

        // Three levels of interpolation per axis, then queue left and right pieces
        function void note_curve(logic [IN_W-1:0] d);
            piece_t left_p, right_p;
            longint t, p0, p1, p2, p3, q0, q1, q2, r0, r1, s;
            t = longint'(d[T_POS +: TW + 1]);
            if (t > T_ONE) begin
                t = T_ONE;
            end
            left_p.coords  = '0;
            right_p.coords = '0;
            left_p.last    = PHASE_LEFT;
            right_p.last   = PHASE_RIGHT;
            for (int a = 0; a < 2; a++) begin
                p0 = longint'($signed(d[(FLD_START_X + a) * CW +: CW]));
                p3 = longint'($signed(d[(FLD_END_X + a) * CW +: CW]));
                p1 = longint'($signed(d[(FLD_CTRLA_X + a) * CW +: CW]));
                p2 = longint'($signed(d[(FLD_CTRLB_X + a) * CW +: CW]));
                q0 = mix(p0, p1, t);
                q1 = mix(p1, p2, t);
                q2 = mix(p2, p3, t);
                r0 = mix(q0, q1, t);
                r1 = mix(q1, q2, t);
                s  = mix(r0, r1, t);
                left_p.coords[(FLD_START_X + a) * CW +: CW]  = p0[CW-1:0];
                left_p.coords[(FLD_END_X + a) * CW +: CW]    = s[CW-1:0];
                left_p.coords[(FLD_CTRLA_X + a) * CW +: CW]  = q0[CW-1:0];
                left_p.coords[(FLD_CTRLB_X + a) * CW +: CW]  = r0[CW-1:0];
                right_p.coords[(FLD_START_X + a) * CW +: CW] = s[CW-1:0];
                right_p.coords[(FLD_END_X + a) * CW +: CW]   = p3[CW-1:0];
                right_p.coords[(FLD_CTRLA_X + a) * CW +: CW] = r1[CW-1:0];
                right_p.coords[(FLD_CTRLB_X + a) * CW +: CW] = q2[CW-1:0];
            end
            pieces_due.push_back(left_p);
            pieces_due.push_back(right_p);
        endfunction

        function void check_piece(logic [OUT_W-1:0] d, logic last);
            piece_t want;
            coord_t w, g;
            if (pieces_due.size() == 0) begin
                $error("piece arrived with none expected: tdata %h tlast %b", d, last);
                mismatches++;
                return;
            end
            want = pieces_due.pop_front();
            for (int k = 0; k < NUM_COORDS; k++) begin
                w = want.coords[k * CW +: CW];
                g = d[k * CW +: CW];
                if (w !== g) begin
                    $error("%s expected %0d got %0d", coord_names[k], w, g);
                    mismatches++;
                end
            end
            if (want.last !== last) begin
                $error("is_last expected %0b got %0b", want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return pieces_due.size();
        endfunction
    endclass

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;

    int unsigned      stall_pct = 0;
    int unsigned      cycles    = 0;
    piece_checker     splitter  = new();

    cubic_bezier_split_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stall the result side at the rate of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Note each accepted curve and check each accepted piece
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            splitter.note_curve(s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            splitter.check_piece(m_tdata, m_tlast);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [IN_W-1:0] pack_curve(curve_pts_t c, logic [TW:0] t);
        logic [IN_W-1:0] d;
        d = '0;
        for (int k = 0; k < NUM_COORDS; k++) begin
            d[k * CW +: CW] = c[k];
        end
        d[T_POS +: TW + 1] = t;
        return d;
    endfunction

    // Hold valid until the item is taken, idling beforehand at the given rate
    task automatic send_curve(curve_pts_t c, logic [TW:0] t, int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_curve(c, t);
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    function automatic coord_t rand_coord();
        int unsigned mode;
        mode = $urandom_range(9);
        case (mode)
            0: begin
                return coord_t'(COORD_MAX);
            end
            1: begin
                return coord_t'(COORD_MIN);
            end
            2, 3: begin
                return coord_t'($signed($urandom_range(511)) - 256);
            end
            default: begin
                return coord_t'($urandom());
            end
        endcase
    endfunction

    function automatic logic [TW:0] rand_t();
        int unsigned mode;
        mode = $urandom_range(19);
        case (mode)
            0: begin
                return '0;
            end
            1: begin
                return (TW + 1)'(T_ONE);
            end
            2, 3: begin
                return (TW + 1)'($urandom_range((1 << (TW + 1)) - 1, T_ONE + 1));
            end
            default: begin
                return (TW + 1)'($urandom_range(T_ONE));
            end
        endcase
    endfunction

    task automatic run_random(int n, int unsigned idle_pct, int unsigned stall);
        curve_pts_t c;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            foreach (c[k]) begin
                c[k] = rand_coord();
            end
            send_curve(c, rand_t(), idle_pct);
        end
    endtask

    task automatic run_directed();
        curve_pts_t c;
        logic [TW:0] ts [8];
        ts = '{'0, 17'd1, 17'd32768, 17'd65535, (TW + 1)'(T_ONE), 17'd65537,
               17'h1FFFF, 17'd21845};
        stall_pct = 0;
        // every coordinate zero, and every coordinate at each extreme
        foreach (c[k]) c[k] = '0;
        send_curve(c, '0, 0);
        foreach (c[k]) c[k] = coord_t'(COORD_MAX);
        send_curve(c, 17'd32768, 0);
        foreach (c[k]) c[k] = coord_t'(COORD_MIN);
        send_curve(c, 17'd32768, 0);
        // extremes alternating between neighbouring points, every special split
        foreach (ts[i]) begin
            foreach (c[k]) begin
                c[k] = ((k / 2 + i) % 2 == 0) ? coord_t'(COORD_MAX) : coord_t'(COORD_MIN);
            end
            send_curve(c, ts[i], 0);
        end
        // one axis at each extreme, the other reversed
        foreach (c[k]) c[k] = (k % 2 == 0) ? coord_t'(COORD_MIN) : coord_t'(COORD_MAX);
        c[FLD_CTRLA_X] = coord_t'(COORD_MAX);
        c[FLD_CTRLB_Y] = coord_t'(COORD_MIN);
        send_curve(c, 17'd49152, 0);
        // odd steps at one half, so rounding lands on exact ties both ways; then a quarter and the smallest t
        c = '{coord_t'(0), coord_t'(0), coord_t'(3), coord_t'(-3),
              coord_t'(1), coord_t'(-1), coord_t'(2), coord_t'(-2)};
        send_curve(c, 17'd32768, 0);
        c = '{coord_t'(-1), coord_t'(1), coord_t'(-7), coord_t'(5),
              coord_t'(0), coord_t'(0), coord_t'(-3), coord_t'(3)};
        send_curve(c, 17'd32768, 0);
        send_curve(c, 17'd16384, 0);
        send_curve(c, 17'd1, 0);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random(140, 0, 0);
        run_random(140, 80, 0);
        run_random(140, 0, 80);
        run_random(130, 37, 37);
        s_tvalid <= 1'b0;
        stall_pct = 0;

        // drain outstanding pieces, then watch for strays
        while (splitter.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (splitter.mismatches == 0 && splitter.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
